[rtl/core/tim_pkg.sv]
package tim_pkg;

  // Bitmap store geometry
  localparam int unsigned BITMAP_BYTES = 128;
  localparam int unsigned BM_AW        = $clog2(BITMAP_BYTES);
  localparam int unsigned CNT_W        = $clog2(BITMAP_BYTES + 1);
  localparam int unsigned POS_W        = $clog2(BITMAP_BYTES + 6);

  // Element layout
  localparam logic [7:0]  TIM_EID      = 8'h05;
  localparam int unsigned HDR_BYTES    = 5;
  localparam int unsigned LEN_BIAS     = 3;
  localparam logic [7:0]  EMPTY_LEN    = 8'd4;
  localparam logic [7:0]  FILL_ONES    = 8'hff;
  localparam logic [7:0]  EVEN_MASK    = 8'hfe;
  localparam int unsigned WORD_BYTES   = 8;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W       = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DTIM_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_FILL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_BYTES  = 2'd2;
  localparam int unsigned CFG_DATA_W      = 8;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_BUILD = 1'b1
  } tim_op_e;

  typedef struct packed {
    logic        opcode;
    logic [6:0]  byte_index;
    logic [7:0]  byte_value;
    logic [7:0]  dtim_countdown;
    logic [10:0] dozing_stations;
  } tim_req_t;

  typedef struct packed {
    logic [63:0] element_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
  } tim_rsp_t;

  // Store write and read requests
  typedef struct packed {
    logic             we;
    logic [BM_AW-1:0] waddr;
    logic [7:0]       wdata;
  } tim_wr_t;

  typedef struct packed {
    logic             re;
    logic [BM_AW-1:0] raddr;
  } tim_rd_t;

endpackage

[rtl/core/tim_bitmap_store.sv]
module tim_bitmap_store (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tim_pkg::tim_wr_t wr_i,
  input  tim_pkg::tim_rd_t rd_i,
  output logic [7:0]       rdata_o
);
  import tim_pkg::*;

  logic [7:0]              mem_q [BITMAP_BYTES];
  logic [BITMAP_BYTES-1:0] vld_q;
  logic [7:0]              rdata_q;
  logic                    rvld_q;

  // Mark entries written since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_i.we) begin
        vld_q[wr_i.waddr] <= 1'b1;
      end
      if (rd_i.re) begin
        rvld_q <= vld_q[rd_i.raddr];
      end
    end
  end

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.waddr] <= wr_i.wdata;
    end
    if (rd_i.re) begin
      rdata_q <= mem_q[rd_i.raddr];
    end
  end

  // Unwritten entries read as zero
  assign rdata_o = rvld_q ? rdata_q : 8'h00;

endmodule

[rtl/core/tim_element_builder.sv]
// Channel   Direction  Handshake                  Payload
// request   in         req_valid_i / req_ready_o  req_i (tim_req_t)
// response  out        rsp_valid_o / rsp_ready_i  rsp_o (tim_rsp_t)
// config    in         cfg_we_i                   cfg_idx_i, cfg_data_i
//
// A write request leaves the block idle; writes can arrive back to back.
// A build request scans the store with one read a cycle (skipped when no station dozes
// or the scan count is zero), then emits one element byte a cycle (length + 2 bytes),
// one word per 8 bytes; the single read port of the bitmap store sets both rates.
// Reset clears the store through per-entry valid bits, with no clearing pass.
// A stalled response holds the byte stream; no new request is taken until the
// element has been handed to the output register.
module tim_element_builder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             req_valid_i,
  output logic                             req_ready_o,
  input  tim_pkg::tim_req_t                req_i,
  output logic                             rsp_valid_o,
  input  logic                             rsp_ready_i,
  output tim_pkg::tim_rsp_t                rsp_o,
  input  logic                             cfg_we_i,
  input  logic [tim_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tim_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import tim_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_EMIT
  } state_e;

  state_e           state_q, state_d;
  logic [7:0]       dtim_period_q, dtim_period_d;
  logic             fill_ones_q, fill_ones_d;
  logic [7:0]       scan_cfg_q, scan_cfg_d;
  logic [7:0]       dcount_q, dcount_d;
  logic             found_q, found_d;
  logic [BM_AW-1:0] n1_q, n1_d;
  logic [BM_AW-1:0] n2_q, n2_d;
  logic [CNT_W-1:0] scan_lim_q, scan_lim_d;
  logic [CNT_W-1:0] sa_q, sa_d;
  logic [BM_AW-1:0] sd_idx_q, sd_idx_d;
  logic             sd_vld_q, sd_vld_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] rd_off_q, rd_off_d;
  logic             dv_q, dv_d;
  logic [63:0]      wbuf_q, wbuf_d;
  logic [2:0]       wcnt_q, wcnt_d;
  tim_rsp_t         rsp_q, rsp_d;
  logic             rsp_valid_q, rsp_valid_d;

  tim_wr_t          st_wr;
  tim_rd_t          st_rd;
  logic [7:0]       rd_byte;

  logic             req_fire;
  logic [CNT_W-1:0] scan_sat;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] rd_addr_full;
  logic [POS_W-1:0] total_len;
  logic             is_last;
  logic             is_hdr;
  logic [7:0]       cur_byte;
  logic             byte_avail;
  logic             completes;
  logic             out_free;
  logic             consume;
  logic             consume_mem;
  logic             issue;
  logic [63:0]      merged;

  tim_bitmap_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (st_wr),
    .rd_i    (st_rd),
    .rdata_o (rd_byte)
  );

  assign req_ready_o = (state_q == ST_IDLE);
  assign req_fire    = req_valid_i && req_ready_o;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // Saturate the configured scan count to the store depth
  assign scan_sat = (32'(scan_cfg_q) > BITMAP_BYTES) ? CNT_W'(BITMAP_BYTES)
                                                     : CNT_W'(scan_cfg_q);

  // Element geometry from the scan result
  assign cnt          = CNT_W'(n2_q) - CNT_W'(n1_q) + CNT_W'(1);
  assign rd_addr_full = CNT_W'(n1_q) + rd_off_q;
  assign total_len    = found_q ? POS_W'(32'(cnt) + HDR_BYTES) : POS_W'(HDR_BYTES + 1);
  assign is_last      = (pos_q == total_len - POS_W'(1));
  assign is_hdr       = (32'(pos_q) < HDR_BYTES);

  // Select the byte at the current stream position
  always_comb begin
    cur_byte = found_q ? rd_byte : (fill_ones_q ? FILL_ONES : 8'h00);
    case (pos_q)
      POS_W'(0): cur_byte = TIM_EID;
      POS_W'(1): cur_byte = found_q ? 8'(32'(cnt) + LEN_BIAS) : EMPTY_LEN;
      POS_W'(2): cur_byte = dcount_q;
      POS_W'(3): cur_byte = dtim_period_q;
      POS_W'(4): cur_byte = found_q ? (8'(n1_q) & EVEN_MASK) : 8'h00;
      default:   ;
    endcase
  end

  // Byte flow control toward the output register
  assign byte_avail  = is_hdr || !found_q || dv_q;
  assign completes   = (wcnt_q == 3'(WORD_BYTES - 1)) || is_last;
  assign out_free    = !rsp_valid_q || rsp_ready_i;
  assign consume     = (state_q == ST_EMIT) && byte_avail && (!completes || out_free);
  assign consume_mem = consume && !is_hdr && found_q;
  assign issue       = (state_q == ST_EMIT) && found_q && (rd_off_q < cnt) &&
                       (!dv_q || consume_mem);

  // Merge the current byte into the word buffer
  always_comb begin
    merged = wbuf_q;
    for (int b = 0; b < WORD_BYTES; b++) begin
      if (3'(b) == wcnt_q) begin
        merged[b*8 +: 8] = cur_byte;
      end
    end
  end

  // Store access requests
  always_comb begin
    st_wr.we    = req_fire && (req_i.opcode == OP_WRITE) &&
                  (32'(req_i.byte_index) < BITMAP_BYTES);
    st_wr.waddr = BM_AW'(req_i.byte_index);
    st_wr.wdata = req_i.byte_value;
    st_rd.re    = (state_q == ST_SCAN) || issue;
    st_rd.raddr = (state_q == ST_SCAN) ? BM_AW'(sa_q) : BM_AW'(rd_addr_full);
  end

  // Next-state logic
  always_comb begin
    state_d       = state_q;
    dtim_period_d = dtim_period_q;
    fill_ones_d   = fill_ones_q;
    scan_cfg_d    = scan_cfg_q;
    dcount_d      = dcount_q;
    found_d       = found_q;
    n1_d          = n1_q;
    n2_d          = n2_q;
    scan_lim_d    = scan_lim_q;
    sa_d          = sa_q;
    sd_idx_d      = sa_q[BM_AW-1:0];
    sd_vld_d      = (state_q == ST_SCAN);
    pos_d         = pos_q;
    rd_off_d      = rd_off_q;
    dv_d          = dv_q;
    wbuf_d        = wbuf_q;
    wcnt_d        = wcnt_q;
    rsp_d         = rsp_q;
    rsp_valid_d   = rsp_valid_q && !rsp_ready_i;

    // Apply configuration writes
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DTIM_PERIOD: dtim_period_d = cfg_data_i;
        CFG_EMPTY_FILL:  fill_ones_d   = cfg_data_i[0];
        CFG_SCAN_BYTES:  scan_cfg_d    = cfg_data_i;
        default:         ;
      endcase
    end

    // Track first and last nonzero bytes while scanning
    if (sd_vld_q && (rd_byte != 8'h00)) begin
      if (!found_q) begin
        n1_d = sd_idx_q & ~BM_AW'(1);
      end
      n2_d    = sd_idx_q;
      found_d = 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (req_fire && (req_i.opcode == OP_BUILD)) begin
          dcount_d   = req_i.dtim_countdown;
          found_d    = 1'b0;
          n1_d       = '0;
          n2_d       = '0;
          scan_lim_d = scan_sat;
          sa_d       = '0;
          pos_d      = '0;
          rd_off_d   = '0;
          dv_d       = 1'b0;
          wbuf_d     = '0;
          wcnt_d     = '0;
          if ((req_i.dozing_stations != 11'd0) && (scan_sat != '0)) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_SCAN: begin
        if (sa_q == scan_lim_q - CNT_W'(1)) begin
          state_d = ST_SCAN_END;
        end else begin
          sa_d = sa_q + CNT_W'(1);
        end
      end
      ST_SCAN_END: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (issue) begin
          rd_off_d = rd_off_q + CNT_W'(1);
          dv_d     = 1'b1;
        end else if (consume_mem) begin
          dv_d = 1'b0;
        end
        if (consume) begin
          pos_d = pos_q + POS_W'(1);
          if (completes) begin
            rsp_d.element_word = merged;
            rsp_d.valid_bytes  = 4'(wcnt_q) + 4'd1;
            rsp_d.last_word    = is_last;
            rsp_valid_d        = 1'b1;
            wbuf_d             = '0;
            wcnt_d             = '0;
            if (is_last) begin
              state_d = ST_IDLE;
            end
          end else begin
            wbuf_d = merged;
            wcnt_d = wcnt_q + 3'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state, configuration and the output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      dtim_period_q <= 8'd1;
      fill_ones_q   <= 1'b0;
      scan_cfg_q    <= 8'd128;
      found_q       <= 1'b0;
      sd_vld_q      <= 1'b0;
      dv_q          <= 1'b0;
      rsp_valid_q   <= 1'b0;
      scan_lim_q    <= '0;
      sa_q          <= '0;
      pos_q         <= '0;
      rd_off_q      <= '0;
      wcnt_q        <= '0;
    end else begin
      state_q       <= state_d;
      dtim_period_q <= dtim_period_d;
      fill_ones_q   <= fill_ones_d;
      scan_cfg_q    <= scan_cfg_d;
      found_q       <= found_d;
      sd_vld_q      <= sd_vld_d;
      dv_q          <= dv_d;
      rsp_valid_q   <= rsp_valid_d;
      scan_lim_q    <= scan_lim_d;
      sa_q          <= sa_d;
      pos_q         <= pos_d;
      rd_off_q      <= rd_off_d;
      wcnt_q        <= wcnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    dcount_q <= dcount_d;
    n1_q     <= n1_d;
    n2_q     <= n2_d;
    sd_idx_q <= sd_idx_d;
    wbuf_q   <= wbuf_d;
    rsp_q    <= rsp_d;
  end

endmodule

[rtl/core/tim_checker.sv]
module tim_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           req_valid_i,
  input logic                           req_ready_o,
  input tim_pkg::tim_req_t              req_i,
  input logic                           rsp_valid_o,
  input logic                           rsp_ready_i,
  input tim_pkg::tim_rsp_t              rsp_o
);
  import tim_pkg::*;

  // Hold a stalled response unchanged
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("response dropped or changed while stalled");

  // Keep the byte count of a word in range
  a_bytes_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.valid_bytes != 4'd0) && (rsp_o.valid_bytes <= 4'd8))
    else $error("valid_bytes out of range");

  // Fill every word but the last
  a_full_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.last_word |-> rsp_o.valid_bytes == 4'd8)
    else $error("short word before the end of an element");

  // Take the next request right after a write
  a_write_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o && (req_i.opcode == OP_WRITE) |=> req_ready_o)
    else $error("not ready after a write request");

endmodule

bind tim_element_builder tim_checker u_tim_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_valid_i),
  .req_ready_o (req_ready_o),
  .req_i       (req_i),
  .rsp_valid_o (rsp_valid_o),
  .rsp_ready_i (rsp_ready_i),
  .rsp_o       (rsp_o)
);
